>>> sv/iir_filter_transposed_df2_macros.svh
// Assertion macros used by the checker file of the IIR filter.
`ifndef IIR_FILTER_TRANSPOSED_DF2_MACROS_SVH
`define IIR_FILTER_TRANSPOSED_DF2_MACROS_SVH

// Checked at every clock edge, suspended while reset is asserted.
`define IIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IIR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/iir_tdf2_pkg.sv
// Shared widths, codes and control/status types of the IIR filter.
package iir_tdf2_pkg;

	localparam int MAX_ORDER_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 5;
	localparam int COEF_W   = 32;
	localparam int ORDER_W  = 5;
	localparam int STATE_W  = 48;
	localparam int COEF_FRAC = 28;

	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	localparam logic [MODE_W-1:0] MODE_SAMPLE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_NUM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD_DEN = 2'd2;

	typedef struct packed {
		logic capture;
		logic wr_num;
		logic wr_den;
		logic issue;
		logic head;
		logic last;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic head_ready;
		logic busy;
		logic out_free;
	} dp_stat_t;

endpackage

>>> sv/iir_filter_transposed_df2.sv
// Transposed direct form II IIR filter for signed 16-bit samples, leading
// denominator coefficient fixed at 1, Q4.28 coefficients, 48-bit saturating
// delay state. A coefficient load (mode 1 or 2) gives no result. A sample
// (mode 0) gives one rounded, clipped output: every tap goes once, one tap per
// cycle, through a single shared pipeline with one 32x16 and one 32x32
// multiplier, after a head pass that forms the output and the feedback value.
// New items are held off while a sample is in work; the output register lets
// the next item in while a result waits to be taken. filter_order 0 runs as 1,
// values above MAX_ORDER run as MAX_ORDER; delay entries beyond the order keep
// their contents.
module iir_filter_transposed_df2 #(
	parameter int MAX_ORDER = iir_tdf2_pkg::MAX_ORDER_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [iir_tdf2_pkg::ORDER_W-1:0]         filter_order,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [iir_tdf2_pkg::MODE_W-1:0]          mode,
	input  logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [iir_tdf2_pkg::IDX_W-1:0]           coef_index,
	input  logic signed [iir_tdf2_pkg::COEF_W-1:0]   coef_value,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                     clipped
);
	import iir_tdf2_pkg::*;

	localparam int AW = $clog2(MAX_ORDER + 1);

	ctl_cmd_t      cmd;
	dp_stat_t      stat;
	logic [AW-1:0] tap;

	iir_tdf2_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.cfg_we       (cfg_we),
		.filter_order (filter_order),
		.stat         (stat),
		.cmd          (cmd),
		.tap          (tap)
	);

	iir_tdf2_dp #(
		.MAX_ORDER(MAX_ORDER)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.tap        (tap),
		.stat       (stat),
		.sample_in  (sample_in),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

endmodule

>>> sv/iir_tdf2_ctrl.sv
// Sequencer of the IIR filter: input handshake, order register and tap pass control.
module iir_tdf2_ctrl #(
	parameter int MAX_ORDER = iir_tdf2_pkg::MAX_ORDER_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [iir_tdf2_pkg::MODE_W-1:0]     mode,
	input  logic                                cfg_we,
	input  logic [iir_tdf2_pkg::ORDER_W-1:0]    filter_order,
	input  iir_tdf2_pkg::dp_stat_t              stat,
	output iir_tdf2_pkg::ctl_cmd_t              cmd,
	output logic [$clog2(MAX_ORDER+1)-1:0]      tap
);
	import iir_tdf2_pkg::*;

	localparam int AW = $clog2(MAX_ORDER + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_HWAIT,
		S_OUTPUT,
		S_TAPS,
		S_DRAIN
	} state_t;

	state_t               state_q;
	logic [ORDER_W-1:0]   order_q;
	logic [AW-1:0]        n_c;
	logic [AW-1:0]        tap_q;
	logic                 issue_q;
	logic                 head_q;
	logic                 last_q;
	logic                 accept;

	// order 0 runs as 1, anything above the build limit runs at the limit
	always_comb begin
		if (order_q == '0) begin
			n_c = AW'(1);
		end else if (int'(order_q) > MAX_ORDER) begin
			n_c = AW'(MAX_ORDER);
		end else begin
			n_c = AW'(order_q);
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign accept       = in_valid && !in_stall;
	assign cmd.capture  = accept && (mode == MODE_SAMPLE);
	assign cmd.wr_num   = accept && (mode == MODE_LOAD_NUM);
	assign cmd.wr_den   = accept && (mode == MODE_LOAD_DEN);
	assign cmd.issue    = issue_q;
	assign cmd.head     = head_q;
	assign cmd.last     = last_q;
	assign cmd.load_out = (state_q == S_OUTPUT) && stat.out_free;
	assign tap          = tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			order_q <= ORDER_W'(1);
			issue_q <= 1'b0;
			head_q  <= 1'b0;
			last_q  <= 1'b0;
			tap_q   <= '0;
		end else begin
			if (cfg_we) begin
				order_q <= filter_order;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_HEAD;
						issue_q <= 1'b1;
						head_q  <= 1'b1;
						last_q  <= 1'b0;
						tap_q   <= '0;
					end
				end
				S_HEAD: begin
					issue_q <= 1'b0;
					head_q  <= 1'b0;
					state_q <= S_HWAIT;
				end
				S_HWAIT: begin
					if (stat.head_ready) begin
						state_q <= S_OUTPUT;
					end
				end
				S_OUTPUT: begin
					if (stat.out_free) begin
						state_q <= S_TAPS;
						issue_q <= 1'b1;
						tap_q   <= AW'(1);
						last_q  <= (n_c == AW'(1));
					end
				end
				S_TAPS: begin
					if (last_q) begin
						issue_q <= 1'b0;
						last_q  <= 1'b0;
						state_q <= S_DRAIN;
					end else begin
						tap_q  <= tap_q + AW'(1);
						last_q <= ((tap_q + AW'(1)) == n_c);
					end
				end
				S_DRAIN: begin
					if (!stat.busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/iir_tdf2_dp.sv
// Datapath of the IIR filter: coefficient and delay memories, MAC pipeline, output register.
module iir_tdf2_dp #(
	parameter int MAX_ORDER = iir_tdf2_pkg::MAX_ORDER_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  iir_tdf2_pkg::ctl_cmd_t                 cmd,
	input  logic [$clog2(MAX_ORDER+1)-1:0]         tap,
	output iir_tdf2_pkg::dp_stat_t                 stat,
	input  logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [iir_tdf2_pkg::IDX_W-1:0]         coef_index,
	input  logic signed [iir_tdf2_pkg::COEF_W-1:0] coef_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                   clipped
);
	import iir_tdf2_pkg::*;

	localparam int AW       = $clog2(MAX_ORDER + 1);
	localparam int DAW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CDEPTH   = MAX_ORDER + 1;
	localparam int PROD_W   = COEF_W + SAMPLE_W;
	localparam int Y_W      = PROD_W + 1;
	localparam int F_SHIFT  = 16;
	localparam int F_W      = STATE_W - F_SHIFT;
	localparam int NEG_W    = 2 * COEF_W + 1;
	localparam int FB_SHIFT = 12;
	localparam int FB_W     = NEG_W - FB_SHIFT;
	localparam int SUM_W    = FB_W + 2;
	localparam int FB_RND   = 1 << (FB_SHIFT - 1);
	localparam int OUT_RND  = 1 << (COEF_FRAC - 1);

	localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};
	localparam logic signed [Y_W-1:0] Y_HI = Y_W'(SAMPLE_MAX) <<< COEF_FRAC;
	localparam logic signed [Y_W-1:0] Y_LO = Y_W'(SAMPLE_MIN) <<< COEF_FRAC;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(ST_MAX)) begin
			return ST_MAX;
		end else if (v < SUM_W'(ST_MIN)) begin
			return ST_MIN;
		end
		return v[STATE_W-1:0];
	endfunction

	// coefficient and delay stores; an entry never written reads as zero
	logic signed [COEF_W-1:0]  num_coef_q [CDEPTH];
	logic signed [COEF_W-1:0]  den_coef_q [CDEPTH];
	logic signed [STATE_W-1:0] dly_q      [MAX_ORDER];
	logic [CDEPTH-1:0]         num_vld_q;
	logic [CDEPTH-1:0]         den_vld_q;
	logic [MAX_ORDER-1:0]      dly_vld_q;

	logic                      idx_ok;
	logic [AW-1:0]             widx;
	logic [DAW-1:0]            dly_raddr;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [F_W-1:0]      f_q;
	logic signed [Y_W-1:0]      y_q;
	logic                       hrdy_q;

	logic                       v_s1, v_s2, v_s3;
	logic                       h_s1, h_s2, h_s3;
	logic signed [COEF_W-1:0]   num_s1, den_s1;
	logic signed [STATE_W-1:0]  dly_s1, dd_s2;
	logic [DAW-1:0]             w_s1, w_s2, w_s3;
	logic signed [PROD_W-1:0]   bx_s2;
	logic signed [2*COEF_W-1:0] af_s2;
	logic signed [Y_W-1:0]      e_s3;
	logic signed [FB_W-1:0]     fb_s3;

	logic signed [NEG_W-1:0]    fb_rnd;
	logic signed [SUM_W-1:0]    tap_sum;
	logic signed [STATE_W-1:0]  dly_new;
	logic signed [STATE_W-1:0]  y_sat;
	logic                       dly_we;

	logic signed [Y_W-1:0]      y_clamp;
	logic signed [Y_W-1:0]      y_rnd;
	logic                       clip_c;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       clipped_q;
	logic                       out_valid_q;

	assign idx_ok    = int'(coef_index) <= MAX_ORDER;
	assign widx      = AW'(coef_index);
	assign dly_raddr = tap[DAW-1:0];

	// feedback term: a * (-f), rounded half up back to the state's fraction
	assign fb_rnd  = NEG_W'(FB_RND) - NEG_W'(af_s2);
	assign tap_sum = SUM_W'(e_s3) + SUM_W'(fb_s3);
	assign dly_new = sat_state(tap_sum);
	assign y_sat   = sat_state(SUM_W'(e_s3));
	assign dly_we  = v_s3 && !h_s3;

	always_comb begin
		y_clamp = y_q;
		clip_c  = 1'b0;
		if (y_q > Y_HI) begin
			y_clamp = Y_HI;
			clip_c  = 1'b1;
		end else if (y_q < Y_LO) begin
			y_clamp = Y_LO;
			clip_c  = 1'b1;
		end
		y_rnd = y_clamp + Y_W'(OUT_RND);
	end

	assign stat.head_ready = hrdy_q;
	assign stat.busy       = v_s1 || v_s2 || v_s3;
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vld_q   <= '0;
			den_vld_q   <= '0;
			dly_vld_q   <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			h_s1        <= 1'b0;
			h_s2        <= 1'b0;
			h_s3        <= 1'b0;
			hrdy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_num && idx_ok) begin
				num_vld_q[widx] <= 1'b1;
			end
			if (cmd.wr_den && idx_ok && (coef_index != '0)) begin
				den_vld_q[widx] <= 1'b1;
			end
			if (dly_we) begin
				dly_vld_q[w_s3] <= 1'b1;
			end
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			h_s1   <= cmd.issue && cmd.head;
			h_s2   <= h_s1;
			h_s3   <= h_s2;
			hrdy_q <= v_s3 && h_s3;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_num && idx_ok) begin
			num_coef_q[widx] <= coef_value;
		end
		if (cmd.wr_den && idx_ok && (coef_index != '0)) begin
			den_coef_q[widx] <= coef_value;
		end
		if (dly_we) begin
			dly_q[w_s3] <= dly_new;
		end
		if (cmd.capture) begin
			x_q <= sample_in;
		end

		// s1: registered reads; the last tap has no delay element above it
		if (cmd.issue) begin
			num_s1 <= num_vld_q[tap] ? num_coef_q[tap] : '0;
			den_s1 <= den_vld_q[tap] ? den_coef_q[tap] : '0;
			dly_s1 <= (cmd.last || !dly_vld_q[dly_raddr]) ? '0 : dly_q[dly_raddr];
			w_s1   <= DAW'(tap - AW'(1));
		end

		// s2: products
		bx_s2 <= num_s1 * x_q;
		af_s2 <= den_s1 * f_q;
		dd_s2 <= dly_s1;
		w_s2  <= w_s1;

		// s3: feedforward sum and rounded feedback
		e_s3  <= Y_W'(bx_s2) + Y_W'(dd_s2);
		fb_s3 <= $signed(fb_rnd[NEG_W-1:FB_SHIFT]);
		w_s3  <= w_s2;

		if (v_s3 && h_s3) begin
			y_q <= e_s3;
			f_q <= $signed(y_sat[STATE_W-1:F_SHIFT]);
		end

		if (cmd.load_out) begin
			sample_out_q <= $signed(y_rnd[COEF_FRAC+SAMPLE_W-1:COEF_FRAC]);
			clipped_q    <= clip_c;
		end
	end

endmodule

>>> sv/iir_tdf2_chk.sv
// Port-level assertions for the IIR filter and their binding to the top level.
`include "iir_filter_transposed_df2_macros.svh"

module iir_tdf2_chk (
	input logic                                     clk,
	input logic                                     arst_n,
	input logic                                     in_valid,
	input logic                                     in_stall,
	input logic [iir_tdf2_pkg::MODE_W-1:0]          mode,
	input logic                                     out_valid,
	input logic                                     out_stall,
	input logic signed [iir_tdf2_pkg::SAMPLE_W-1:0] sample_out,
	input logic                                     clipped
);
	import iir_tdf2_pkg::*;

	// a held result keeps its value
	`IIR_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(sample_out) && $stable(clipped)), "stalled result changed")

	// the edge that applies reset may see the output register still unknown
	`IIR_ASSERT_ALWAYS(a_out_reset, !arst_n |=> !out_valid, "result valid during reset")

	// a sample item keeps the block busy afterwards
	`IIR_ASSERT(a_sample_busy, (in_valid && !in_stall && (mode == MODE_SAMPLE)) |=> in_stall, "sample item did not occupy the block")

	// coefficient loads and unknown modes complete at once
	`IIR_ASSERT(a_load_free, (in_valid && !in_stall && (mode != MODE_SAMPLE)) |=> !in_stall, "non-sample item stalled the input")

	// a new result is issued only from inside a sample pass
	`IIR_ASSERT(a_out_in_pass, $rose(out_valid) |-> in_stall, "result appeared outside a sample pass")

endmodule

bind iir_filter_transposed_df2 iir_tdf2_chk u_chk (.*);
